/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SSU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ssu assertion failed");

// Checked at every clock edge, reset included.
`define SSU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("ssu assertion failed");

`endif

/* rtl/ssu_pkg.sv */
package ssu_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_PUSH  = 2'd2;

    localparam logic [2:0] MODE_ASSIGN = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_SUB    = 3'd2;
    localparam logic [2:0] MODE_MUL    = 3'd3;
    localparam logic [2:0] MODE_MAX    = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_IDENTITY  = 3'd1;
    localparam logic [2:0] STAT_AXIS      = 3'd2;
    localparam logic [2:0] STAT_INPUT     = 3'd3;
    localparam logic [2:0] STAT_DUPLICATE = 3'd4;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS     = 8'd4;

    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        slot_index;
        logic signed [63:0] data_value;
        logic               last_in_batch;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic signed [63:0] read_value;
        logic [2:0]         batch_status;
        logic [8:0]         applied_count;
    } t_out_item;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] idx;
        logic [63:0] val;
        logic        last;
        logic        in_depth;
    } t_work;

    typedef struct packed {
        logic [2:0]  update_mode;
        logic        require_unique;
        logic [10:0] target_length;
        logic        identity_ok;
        logic        axis_ok;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_EMIT_RD,
        ST_DUP_RD,
        ST_DUP_CMP,
        ST_APP_RD,
        ST_APP_CHK,
        ST_APP_OP,
        ST_MUL,
        ST_MUL_RND,
        ST_MUL_FIN,
        ST_EMIT_ST
    } t_state;

endpackage

/* rtl/ssu_front.sv */
module ssu_front #(
    parameter int TARGET_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  ssu_pkg::t_in_item i_item,
    output logic             o_q_valid,
    output ssu_pkg::t_work   o_q_data,
    input  logic             i_q_pop
);
    import ssu_pkg::*;
    `include "assert_macros.svh"

    localparam logic [31:0] DEPTH32 = 32'(TARGET_DEPTH);

    t_work      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_work      w_cls;
    logic       w_push_ok;
    logic       w_pop_ok;

    always_comb begin
        w_cls.cmd      = i_item.command;
        w_cls.idx      = i_item.slot_index;
        w_cls.val      = i_item.data_value;
        w_cls.last     = i_item.last_in_batch;
        w_cls.in_depth = i_item.slot_index < DEPTH32;
    end

    assign full      = r_count == 2'd2;
    assign o_q_valid = r_count != 2'd0;
    assign o_q_data  = r_slot[r_rd_ptr];
    assign w_push_ok = push && !full;
    assign w_pop_ok  = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[r_wr_ptr] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push_ok} - {1'b0, w_pop_ok};
        end
    end

    `SSU_ASSERT(a_count_bound, r_count != 2'd3)
    `SSU_ASSERT(a_push_grows, w_push_ok && !w_pop_ok |=> r_count == $past(r_count) + 2'd1)
    `SSU_ASSERT(a_ptr_gap, (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))

endmodule

/* rtl/ssu_back.sv */
module ssu_back #(
    parameter int TARGET_DEPTH = 1024,
    parameter int MAX_BATCH    = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssu_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  ssu_pkg::t_work     i_q_data,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output ssu_pkg::t_out_item o_out,
    input  logic               i_out_pop
);
    import ssu_pkg::*;
    `include "assert_macros.svh"

    localparam int AW  = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
    localparam int PAW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int NW  = $clog2(MAX_BATCH + 1) + 1;
    localparam logic [31:0] DEPTH32 = 32'(TARGET_DEPTH);
    localparam logic [NW-1:0] MAXB  = NW'(MAX_BATCH);

    logic [63:0] r_tgt_mem [TARGET_DEPTH];
    logic [31:0] r_pidx_mem [MAX_BATCH];
    logic [63:0] r_pval_mem [MAX_BATCH];

    t_state      r_state, n_state;
    t_work       r_wk, n_wk;
    logic [NW-1:0] r_cnt, n_cnt;
    logic        r_ovf, n_ovf;
    logic [NW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [2:0]  r_status, n_status;
    logic [63:0] r_ma, n_ma, r_mb, n_mb;
    logic        r_neg, n_neg;
    logic [127:0] r_acc, n_acc;
    logic [1:0]  r_mstep, n_mstep;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic [63:0] r_tgt_q, r_pval_q;
    logic [31:0] r_pidx_q, r_pidx2_q;

    logic          tgt_we, tgt_re, pend_we, pend_re, dup_re;
    logic [AW-1:0] tgt_wa, tgt_ra;
    logic [63:0]   tgt_wd;
    logic [PAW-1:0] pend_wa, pend_ra0, pend_ra1;

    logic [31:0]  w_limit;
    logic         w_out_free;
    logic         w_ovf_new;
    logic [64:0]  w_sum, w_diff;
    logic [63:0]  w_comb, w_mul_res, w_mag;
    logic [31:0]  w_fa, w_fb;
    logic [63:0]  w_prod;
    logic [127:0] w_prod_sh;
    logic [NW+8:0] w_cnt_ext;

    assign w_limit = ({21'd0, i_cfg.target_length} > DEPTH32) ? DEPTH32
                                                             : {21'd0, i_cfg.target_length};
    assign w_out_free  = !r_out_valid || i_out_pop;
    assign w_ovf_new   = r_ovf || (r_cnt == MAXB);
    assign w_cnt_ext   = {9'd0, r_k};
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Combine operation on the old word r_tgt_q and operand r_pval_q.
    always_comb begin
        w_sum  = {r_tgt_q[63], r_tgt_q} + {r_pval_q[63], r_pval_q};
        w_diff = {r_tgt_q[63], r_tgt_q} - {r_pval_q[63], r_pval_q};
        case (i_cfg.update_mode)
            MODE_ASSIGN: w_comb = r_pval_q;
            MODE_ADD:    w_comb = (w_sum[64] != w_sum[63])
                                  ? (w_sum[64] ? SAT_MIN : SAT_MAX) : w_sum[63:0];
            MODE_SUB:    w_comb = (w_diff[64] != w_diff[63])
                                  ? (w_diff[64] ? SAT_MIN : SAT_MAX) : w_diff[63:0];
            MODE_MAX:    w_comb = ($signed(r_tgt_q) < $signed(r_pval_q)) ? r_pval_q : r_tgt_q;
            default:     w_comb = r_tgt_q;
        endcase
    end

    // One 32x32 partial product per cycle, accumulated at its weight.
    always_comb begin
        w_fa      = r_mstep[1] ? r_ma[63:32] : r_ma[31:0];
        w_fb      = r_mstep[0] ? r_mb[63:32] : r_mb[31:0];
        w_prod    = {32'd0, w_fa} * {32'd0, w_fb};
        w_prod_sh = {64'd0, w_prod} << {({1'b0, r_mstep[1]} + {1'b0, r_mstep[0]}), 5'd0};
        w_mag     = r_acc[95:32];
        if (r_acc[127:96] != 32'd0) begin
            w_mul_res = r_neg ? SAT_MIN : SAT_MAX;
        end else if (r_neg) begin
            w_mul_res = w_mag[63] ? SAT_MIN : (~w_mag + 64'd1);
        end else begin
            w_mul_res = w_mag[63] ? SAT_MAX : w_mag;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                case (r_wk.cmd)
                    CMD_READ: n_state = ST_EMIT_RD;
                    CMD_PUSH: begin
                        if (!r_wk.last) begin
                            n_state = ST_IDLE;
                        end else if (!i_cfg.identity_ok || !i_cfg.axis_ok || w_ovf_new) begin
                            n_state = ST_EMIT_ST;
                        end else if (i_cfg.require_unique) begin
                            n_state = ST_DUP_RD;
                        end else begin
                            n_state = ST_APP_RD;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_EMIT_RD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DUP_RD: begin
                if (r_i + NW'(1) >= r_cnt) begin
                    n_state = ST_APP_RD;
                end else if (r_j < r_cnt) begin
                    n_state = ST_DUP_CMP;
                end
            end
            ST_DUP_CMP: n_state = (r_pidx_q == r_pidx2_q) ? ST_EMIT_ST : ST_DUP_RD;
            ST_APP_RD:  n_state = (r_k >= r_cnt) ? ST_EMIT_ST : ST_APP_CHK;
            ST_APP_CHK: n_state = (r_pidx_q >= w_limit) ? ST_EMIT_ST : ST_APP_OP;
            ST_APP_OP:  n_state = (i_cfg.update_mode == MODE_MUL) ? ST_MUL : ST_APP_RD;
            ST_MUL: begin
                if (r_mstep == 2'd3) begin
                    n_state = ST_MUL_RND;
                end
            end
            ST_MUL_RND: n_state = ST_MUL_FIN;
            ST_MUL_FIN: n_state = ST_APP_RD;
            ST_EMIT_ST: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_wk        = r_wk;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_status    = r_status;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_mstep     = r_mstep;
        n_out_valid = r_out_valid && !i_out_pop;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        tgt_we      = 1'b0;
        tgt_re      = 1'b0;
        tgt_wa      = r_wk.idx[AW-1:0];
        tgt_ra      = r_wk.idx[AW-1:0];
        tgt_wd      = r_wk.val;
        pend_we     = 1'b0;
        pend_re     = 1'b0;
        dup_re      = 1'b0;
        pend_wa     = r_cnt[PAW-1:0];
        pend_ra0    = r_k[PAW-1:0];
        pend_ra1    = r_j[PAW-1:0];
        case (r_state)
            ST_IDLE: begin
                o_q_pop = i_q_valid;
                n_wk    = i_q_data;
            end
            ST_DISP: begin
                case (r_wk.cmd)
                    CMD_WRITE: tgt_we = r_wk.in_depth;
                    CMD_READ:  tgt_re = r_wk.in_depth;
                    CMD_PUSH: begin
                        if (r_cnt == MAXB) begin
                            n_ovf = 1'b1;
                        end else begin
                            pend_we = 1'b1;
                            n_cnt   = r_cnt + NW'(1);
                        end
                        n_i = '0;
                        n_j = NW'(1);
                        n_k = '0;
                        if (!i_cfg.identity_ok) begin
                            n_status = STAT_IDENTITY;
                        end else if (!i_cfg.axis_ok) begin
                            n_status = STAT_AXIS;
                        end else if (w_ovf_new) begin
                            n_status = STAT_INPUT;
                        end else begin
                            n_status = STAT_OK;
                        end
                    end
                    default: ;
                endcase
            end
            ST_EMIT_RD: begin
                if (w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.result_kind   = KIND_READ;
                    n_out.read_value    = r_wk.in_depth ? r_tgt_q : 64'd0;
                    n_out.batch_status  = STAT_OK;
                    n_out.applied_count = 9'd0;
                end
            end
            ST_DUP_RD: begin
                pend_ra0 = r_i[PAW-1:0];
                if (r_i + NW'(1) < r_cnt) begin
                    if (r_j >= r_cnt) begin
                        n_i = r_i + NW'(1);
                        n_j = r_i + NW'(2);
                    end else begin
                        dup_re = 1'b1;
                    end
                end
            end
            ST_DUP_CMP: begin
                n_j = r_j + NW'(1);
                if (r_pidx_q == r_pidx2_q) begin
                    n_status = STAT_DUPLICATE;
                end
            end
            ST_APP_RD: begin
                pend_re = r_k < r_cnt;
            end
            ST_APP_CHK: begin
                tgt_ra = r_pidx_q[AW-1:0];
                if (r_pidx_q >= w_limit) begin
                    n_status = STAT_INPUT;
                end else begin
                    tgt_re = 1'b1;
                end
            end
            ST_APP_OP: begin
                tgt_wa = r_pidx_q[AW-1:0];
                n_ma   = r_tgt_q[63] ? (~r_tgt_q + 64'd1) : r_tgt_q;
                n_mb   = r_pval_q[63] ? (~r_pval_q + 64'd1) : r_pval_q;
                n_neg  = r_tgt_q[63] ^ r_pval_q[63];
                n_acc  = '0;
                n_mstep = 2'd0;
                if (i_cfg.update_mode != MODE_MUL) begin
                    tgt_we = 1'b1;
                    tgt_wd = w_comb;
                    n_k    = r_k + NW'(1);
                end
            end
            ST_MUL: begin
                n_acc   = r_acc + w_prod_sh;
                n_mstep = r_mstep + 2'd1;
            end
            ST_MUL_RND: begin
                n_acc = r_acc + 128'h8000_0000;
            end
            ST_MUL_FIN: begin
                tgt_wa = r_pidx_q[AW-1:0];
                tgt_we = 1'b1;
                tgt_wd = w_mul_res;
                n_k    = r_k + NW'(1);
            end
            ST_EMIT_ST: begin
                if (w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.result_kind   = KIND_STATUS;
                    n_out.read_value    = 64'd0;
                    n_out.batch_status  = r_status;
                    n_out.applied_count = w_cnt_ext[8:0];
                    n_cnt               = '0;
                    n_ovf               = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[tgt_wa] <= tgt_wd;
        end
        if (tgt_re) begin
            r_tgt_q <= r_tgt_mem[tgt_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            r_pidx_mem[pend_wa] <= r_wk.idx;
            r_pval_mem[pend_wa] <= r_wk.val;
        end
        if (pend_re || dup_re) begin
            r_pidx_q <= r_pidx_mem[pend_ra0];
        end
        if (pend_re) begin
            r_pval_q <= r_pval_mem[pend_ra0];
        end
        if (dup_re) begin
            r_pidx2_q <= r_pidx_mem[pend_ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_wk     <= n_wk;
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_status <= n_status;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_neg    <= n_neg;
        r_acc    <= n_acc;
        r_mstep  <= n_mstep;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    `SSU_ASSERT(a_cnt_bound, r_cnt <= MAXB)
    `SSU_ASSERT(a_out_hold, r_out_valid && !i_out_pop |=> r_out_valid && $stable(r_out))
    `SSU_ASSERT(a_mul_steps, (r_state == ST_MUL_RND) |-> ($past(r_state) == ST_MUL))

endmodule

/* rtl/sparse_scatter_update.sv */
// Accepted requests wait in a two-entry queue, and the back end takes them one at a time.
// A batch end runs a duplicate scan over the n pairs in unique mode, then applies the pairs in
// turn (in multiply mode one 32x32 multiplier runs four partial products), then posts the status.
// A full output register stalls the back end.
// Reset is synchronous, active low: it clears the queues and pending count and restores the
// configuration defaults.
module sparse_scatter_update #(
    parameter int TARGET_DEPTH = 1024,
    parameter int MAX_BATCH    = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  ssu_pkg::t_in_item                   i_in_item,
    output logic                                empty,
    input  logic                                pop,
    output ssu_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ssu_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ssu_pkg::*;

    t_cfg  r_cfg;
    logic  q_valid, q_pop, out_valid;
    t_work q_data;

    assign o_cfg_ready = 1'b1;
    assign empty       = !out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.update_mode    <= MODE_ASSIGN;
            r_cfg.require_unique <= 1'b0;
            r_cfg.target_length  <= 11'd1024;
            r_cfg.identity_ok    <= 1'b1;
            r_cfg.axis_ok        <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:     r_cfg.update_mode    <= i_cfg_data[2:0];
                CFG_UNIQUE:   r_cfg.require_unique <= i_cfg_data[0];
                CFG_LENGTH:   r_cfg.target_length  <= i_cfg_data[10:0];
                CFG_IDENTITY: r_cfg.identity_ok    <= i_cfg_data[0];
                CFG_AXIS:     r_cfg.axis_ok        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ssu_front #(
        .TARGET_DEPTH(TARGET_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_in_item),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    ssu_back #(
        .TARGET_DEPTH(TARGET_DEPTH),
        .MAX_BATCH   (MAX_BATCH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_out_valid (out_valid),
        .o_out       (o_out_item),
        .i_out_pop   (pop)
    );

endmodule

/* tb/scatter_update_checker.sv */
module scatter_update_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic                             i_full,
    input  ssu_pkg::t_in_item                i_in_item,
    input  logic                             i_empty,
    input  logic                             i_pop,
    input  ssu_pkg::t_out_item               i_out_item,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [ssu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ssu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_fail_count,
    output int                               o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssu_pkg::*;

    localparam int DEPTH = 1024;
    localparam int BATCH = 256;

    logic [63:0] vector_words [DEPTH];
    logic [31:0] batch_index [BATCH];
    logic [63:0] batch_value [BATCH];
    int          batch_fill;
    logic        batch_overflow;

    logic [2:0]  mode_reg;
    logic        unique_reg;
    logic [10:0] length_reg;
    logic        identity_reg;
    logic        axis_reg;

    t_out_item   expected_results [$];

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return a[63] ? SAT_MIN : SAT_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return a[63] ? SAT_MIN : SAT_MAX;
        return s[63:0];
    endfunction

    // Magnitude product, rounded half away from zero at bit 32, then clamped.
    function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
        logic        neg;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [127:0] m;
        neg = a[63] ^ b[63];
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        m = {64'd0, ma} * {64'd0, mb};
        m = (m + 128'h8000_0000) >> 32;
        if (neg) return (m >= 128'h8000_0000_0000_0000) ? SAT_MIN : -m[63:0];
        return (m > {64'd0, SAT_MAX}) ? SAT_MAX : m[63:0];
    endfunction

    function automatic logic [63:0] combine_word(logic [63:0] old, logic [63:0] v);
        case (mode_reg)
            MODE_ASSIGN: return v;
            MODE_ADD:    return sat_add(old, v);
            MODE_SUB:    return sat_sub(old, v);
            MODE_MUL:    return mul_q32(old, v);
            MODE_MAX:    return ($signed(old) < $signed(v)) ? v : old;
            default:     return old;
        endcase
    endfunction

    function automatic t_out_item settle_batch();
        t_out_item r;
        int        lim;
        r = '0;
        r.result_kind = KIND_STATUS;
        lim = (length_reg > DEPTH) ? DEPTH : int'(length_reg);
        if (!identity_reg) r.batch_status = STAT_IDENTITY;
        else if (!axis_reg) r.batch_status = STAT_AXIS;
        else if (batch_overflow) r.batch_status = STAT_INPUT;
        else begin
            r.batch_status = STAT_OK;
            if (unique_reg) begin
                for (int i = 0; i < batch_fill; i++)
                    for (int j = i + 1; j < batch_fill; j++)
                        if (batch_index[i] == batch_index[j]) r.batch_status = STAT_DUPLICATE;
            end
            if (r.batch_status == STAT_OK) begin
                for (int k = 0; k < batch_fill; k++) begin
                    if (batch_index[k] >= lim) begin
                        r.batch_status = STAT_INPUT;
                        break;
                    end
                    vector_words[batch_index[k]] =
                        combine_word(vector_words[batch_index[k]], batch_value[k]);
                    r.applied_count = 9'(k + 1);
                end
            end
        end
        return r;
    endfunction

    task automatic apply_request(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.command)
            CMD_WRITE: if (it.slot_index < DEPTH) vector_words[it.slot_index] = it.data_value;
            CMD_READ: begin
                r.result_kind = KIND_READ;
                r.read_value = (it.slot_index < DEPTH) ? vector_words[it.slot_index] : '0;
                expected_results.push_back(r);
            end
            CMD_PUSH: begin
                if (batch_fill < BATCH) begin
                    batch_index[batch_fill] = it.slot_index;
                    batch_value[batch_fill] = it.data_value;
                    batch_fill++;
                end else begin
                    batch_overflow = 1'b1;
                end
                if (it.last_in_batch) begin
                    expected_results.push_back(settle_batch());
                    batch_fill = 0;
                    batch_overflow = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: kind %0d", got.result_kind);
            o_fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind) begin
            $error("result_kind expected %0d actual %0d", want.result_kind, got.result_kind);
            o_fail_count++;
        end
        if (got.read_value !== want.read_value) begin
            $error("read_value expected %h actual %h", want.read_value, got.read_value);
            o_fail_count++;
        end
        if (got.batch_status !== want.batch_status) begin
            $error("batch_status expected %0d actual %0d", want.batch_status,
                   got.batch_status);
            o_fail_count++;
        end
        if (got.applied_count !== want.applied_count) begin
            $error("applied_count expected %0d actual %0d", want.applied_count,
                   got.applied_count);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count = 0;
            batch_fill = 0;
            batch_overflow = 1'b0;
            mode_reg = MODE_ASSIGN;
            unique_reg = 1'b0;
            length_reg = 11'd1024;
            identity_reg = 1'b1;
            axis_reg = 1'b1;
            expected_results.delete();
        end else begin
            if (i_pop && !i_empty) check_result(i_out_item);
            if (i_push && !i_full) apply_request(i_in_item);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:     mode_reg = i_cfg_data[2:0];
                    CFG_UNIQUE:   unique_reg = i_cfg_data[0];
                    CFG_LENGTH:   length_reg = i_cfg_data[10:0];
                    CFG_IDENTITY: identity_reg = i_cfg_data[0];
                    CFG_AXIS:     axis_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_waiting = expected_results.size();
    end

endmodule

/* tb/sparse_scatter_update_tb.sv */
module sparse_scatter_update_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssu_pkg::*;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Only the low part of the store is filled up front and used for in-range reads and batches.
    localparam int USED_WORDS = 256;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic push;
    logic full;
    t_in_item i_in_item;
    logic empty;
    logic pop;
    t_out_item o_out_item;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int fail_count;
    int waiting;

    // When set, neither side inserts gaps between requests.
    logic no_gaps = 1'b0;
    int   length_now = 1024;

    sparse_scatter_update i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in_item(i_in_item),
        .empty(empty), .pop(pop), .o_out_item(o_out_item), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    scatter_update_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_in_item(i_in_item), .i_empty(empty), .i_pop(pop), .i_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_fail_count(fail_count), .o_waiting(waiting)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #40ms;
        $display("sparse_scatter_update test failed");
        $finish;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic [63:0] draw_value();
        case ($urandom_range(0, 7))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return 64'd0;
            3: return 64'h0000_0001_0000_0000;
            4: return 64'hFFFF_FFFF_0000_0000;
            5: return 64'($signed($urandom_range(0, 65535)) - 32768) << 16;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // An index that is always beyond the store.
    function automatic logic [31:0] draw_far();
        return $urandom | 32'h0000_0400;
    endfunction

    task automatic send(logic [1:0] cmd, logic [31:0] idx, logic [63:0] val, logic last);
        int  gap;
        bit  taken;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= '{command: cmd, slot_index: idx, data_value: val, last_in_batch: last};
        do begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Indices mostly in range; a narrow range makes repeats likely.
    function automatic logic [31:0] draw_slot(bit narrow);
        int lim;
        lim = (length_now > USED_WORDS) ? USED_WORDS : length_now;
        if (lim == 0 || $urandom_range(0, 15) == 0) return draw_far();
        if (narrow) return $urandom_range(0, ((lim < 8) ? lim : 8) - 1);
        return $urandom_range(0, lim - 1);
    endfunction

    task automatic send_batch(int n, bit narrow);
        for (int k = 0; k < n; k++)
            send(CMD_PUSH, draw_slot(narrow), draw_value(), k == n - 1);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(negedge i_clk); while (waiting != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx == CFG_LENGTH) length_now = int'(data[10:0]);
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(int mode, int uniq, int len, int ident, int axis);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_UNIQUE, uniq);
        write_reg(CFG_LENGTH, len);
        write_reg(CFG_IDENTITY, ident);
        write_reg(CFG_AXIS, axis);
    endtask

    // Result side: random pops, with one long hold to back the block up.
    initial begin
        int  gap;
        int  seen;
        bit  held;
        bit  taken;
        seen = 0;
        held = 1'b0;
        pop = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = draw_gap();
            if (!held && seen >= 100) begin
                held = 1'b1;
                gap = 1500;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(negedge i_clk);
                taken = !empty;
                @(posedge i_clk);
            end while (!taken);
            seen++;
        end
    end

    initial begin
        int sent;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the used words so no read ever touches an unwritten word.
        no_gaps = 1'b1;
        for (int i = 0; i < USED_WORDS; i++) send(CMD_WRITE, i, draw_value(), 1'b0);
        no_gaps = 1'b0;

        send(CMD_WRITE, 5, SAT_MAX, 1'b0);
        send(CMD_WRITE, 6, SAT_MIN, 1'b0);
        send(CMD_WRITE, 32'hFFFF_FFFF, SAT_MAX, 1'b1);
        send(CMD_READ, 0, 64'd0, 1'b0);
        send(CMD_READ, USED_WORDS - 1, 64'd0, 1'b0);
        send(CMD_READ, 1024, SAT_MIN, 1'b1);
        send(CMD_READ, 32'hFFFF_FFFF, 64'd0, 1'b0);
        send(CMD_UNUSED, 32'hFFFF_FFFF, SAT_MAX, 1'b1);
        for (int m = MODE_ASSIGN; m <= MODE_MAX; m++) begin
            wait_idle();
            write_reg(CFG_MODE, m);
            send(CMD_PUSH, 5, SAT_MAX, 1'b0);
            send(CMD_PUSH, 6, 64'hFFFF_FFFF_8000_0000, 1'b1);
        end
        wait_idle();
        set_all(7, 1, 3, 1, 1);
        send(CMD_PUSH, 1, 64'd1, 1'b0);
        send(CMD_PUSH, 1, 64'd2, 1'b1);
        wait_idle();
        write_reg(CFG_UNIQUE, 0);
        send(CMD_PUSH, 1, 64'd1, 1'b0);
        send(CMD_PUSH, 3, 64'd2, 1'b0);
        send(CMD_PUSH, 2, 64'd3, 1'b1);
        wait_idle();
        set_all(MODE_ADD, 0, 2047, 0, 1);
        send(CMD_PUSH, 1, 64'd1, 1'b1);
        wait_idle();
        set_all(MODE_ADD, 0, 0, 1, 0);
        send(CMD_PUSH, 1, 64'd1, 1'b1);
        wait_idle();
        write_reg(CFG_AXIS, 1);
        send(CMD_PUSH, 0, 64'd1, 1'b1);

        // Largest batch, then one pair too many.
        wait_idle();
        set_all(MODE_ADD, 0, 1024, 1, 1);
        no_gaps = 1'b1;
        for (int k = 0; k < 256; k++) send(CMD_PUSH, k, draw_value(), k == 255);
        for (int k = 0; k < 257; k++) send(CMD_PUSH, k, draw_value(), k == 256);
        no_gaps = 1'b0;

        for (int phase = 0; phase < 12; phase++) begin
            wait_idle();
            case (phase)
                0: set_all(MODE_MUL, 0, 1024, 1, 1);
                1: set_all(MODE_MAX, 1, 1, 1, 1);
                2: set_all(MODE_SUB, 1, 2047, 1, 1);
                default: set_all($urandom_range(0, 7), $urandom_range(0, 1),
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                             : $urandom_range(1000, 1100),
                                 $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
            endcase
            no_gaps = (phase % 4 == 3);
            sent = 0;
            while (sent < 60) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send(CMD_WRITE, ($urandom_range(0, 7) == 0) ? $urandom
                                        : $urandom_range(0, 1023), draw_value(),
                             $urandom_range(0, 1));
                        sent++;
                    end
                    1, 2: begin
                        send(CMD_READ, ($urandom_range(0, 7) == 0) ? draw_far()
                                       : $urandom_range(0, USED_WORDS - 1), draw_value(),
                             $urandom_range(0, 1));
                        sent++;
                    end
                    3: send(CMD_UNUSED, $urandom, draw_value(), $urandom_range(0, 1));
                    default: begin
                        int n;
                        n = $urandom_range(1, 8);
                        send_batch(n, $urandom_range(0, 2) == 0);
                        sent += n;
                    end
                endcase
            end
        end

        push <= 1'b0;
        do @(negedge i_clk); while (waiting != 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && waiting == 0)
            $display("sparse_scatter_update test passed");
        else
            $display("sparse_scatter_update test failed");
        $finish;
    end

endmodule
